// ===== rtl/core/owrs_pkg.sv =====
`default_nettype none

package owrs_pkg;

    localparam int ADDRESS_BITS = 64;
    localparam int IDX_W = $clog2(ADDRESS_BITS + 1);
    localparam int BIT_W = (ADDRESS_BITS > 1) ? $clog2(ADDRESS_BITS) : 1;
    localparam logic [63:0] ADDR_MASK = (ADDRESS_BITS >= 64) ? {64{1'b1}}
                                      : ((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [IDX_W-1:0] NO_BRANCH = IDX_W'(ADDRESS_BITS);

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [1:0] KIND_FIRST    = 2'd0;
    localparam logic [1:0] KIND_NEXT     = 2'd1;
    localparam logic [1:0] KIND_PRESENCE = 2'd2;
    localparam logic [1:0] KIND_PAIR     = 2'd3;

    localparam logic [2:0] ACT_RESET      = 3'd0;
    localparam logic [2:0] ACT_BYTE       = 3'd1;
    localparam logic [2:0] ACT_WRITE      = 3'd2;
    localparam logic [2:0] ACT_FOUND      = 3'd3;
    localparam logic [2:0] ACT_NONE       = 3'd4;
    localparam logic [2:0] ACT_VANISHED   = 3'd5;
    localparam logic [2:0] ACT_NOTPRESENT = 3'd6;

    localparam logic [7:0] CMD_SEARCH = 8'hF0;
    localparam logic [7:0] CMD_ALARM  = 8'hEC;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_PRES_FIRST = 3'd1,
        PH_TRAVERSE   = 3'd2,
        PH_PRES_DESC  = 3'd3,
        PH_DESCEND    = 3'd4,
        PH_PRES_NEXT  = 3'd5,
        PH_TRACK      = 3'd6
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        alarm;
        logic [63:0] address_in;
        logic        present;
        logic        id_bit;
        logic        cmp_bit;
    } item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  value;
        logic [63:0] address_out;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(input logic [2:0] act, input logic [7:0] val,
                                            input logic [63:0] addr, input logic last);
        result_t r;
        r.action      = act;
        r.value       = val;
        r.address_out = addr;
        r.last        = last;
        return r;
    endfunction

    function automatic logic pair_ok(input logic id, input logic cmp, input logic a);
        return !(id && cmp) && !((id != cmp) && (id != a));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/owrs_decide.sv =====
`default_nettype none

module owrs_decide (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire owrs_pkg::item_t item,
    output owrs_pkg::push_t      push
);
    import owrs_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [IDX_W-1:0]  branch_index_reg, branch_index_next;
    logic [63:0]       work_address_reg, work_address_next;
    logic              alarm_flag_reg, alarm_flag_next;

    logic [BIT_W-1:0]  bit_sel;
    logic [IDX_W-1:0]  index_inc;
    logic              addr_bit;
    logic [63:0]       work_upd;

    assign bit_sel   = bit_index_reg[BIT_W-1:0];
    assign index_inc = bit_index_reg + IDX_W'(1);
    assign addr_bit  = work_address_reg[bit_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_index_reg    <= '0;
            branch_index_reg <= NO_BRANCH;
            work_address_reg <= '0;
            alarm_flag_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            branch_index_reg <= branch_index_next;
            work_address_reg <= work_address_next;
            alarm_flag_reg   <= alarm_flag_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        branch_index_next = branch_index_reg;
        work_address_next = work_address_reg;
        alarm_flag_next   = alarm_flag_reg;
        work_upd          = work_address_reg;
        push.count        = 2'd0;
        push.first        = make_result(ACT_RESET, 8'd0, 64'd0, 1'b1);
        push.second       = make_result(ACT_RESET, 8'd0, 64'd0, 1'b1);

        case (item.kind)
            KIND_FIRST, KIND_NEXT:
            begin
                alarm_flag_next   = item.alarm;
                bit_index_next    = '0;
                branch_index_next = NO_BRANCH;
                if (item.kind == KIND_FIRST)
                begin
                    work_address_next = '0;
                    phase_next        = PH_PRES_FIRST;
                end
                else
                begin
                    work_address_next = item.address_in & ADDR_MASK;
                    phase_next        = PH_PRES_DESC;
                end
                push.count = 2'd1;
            end
            KIND_PRESENCE:
            begin
                if (phase_reg == PH_PRES_FIRST || phase_reg == PH_PRES_DESC
                    || phase_reg == PH_PRES_NEXT)
                begin
                    push.count = 2'd1;
                    if (!item.present)
                    begin
                        phase_next = PH_IDLE;
                        if (phase_reg == PH_PRES_FIRST)
                            push.first.action = ACT_NONE;
                        else if (phase_reg == PH_PRES_DESC)
                            push.first.action = ACT_VANISHED;
                        else
                            push.first.action = ACT_NOTPRESENT;
                    end
                    else
                    begin
                        if (phase_reg == PH_PRES_FIRST)
                            phase_next = PH_TRAVERSE;
                        else if (phase_reg == PH_PRES_DESC)
                            phase_next = PH_DESCEND;
                        else
                            phase_next = PH_TRACK;
                        bit_index_next    = '0;
                        push.first.action = ACT_BYTE;
                        push.first.value  = alarm_flag_reg ? CMD_ALARM : CMD_SEARCH;
                    end
                end
            end
            default:
            begin
                case (phase_reg)
                    PH_TRAVERSE:
                    begin
                        push.count = 2'd1;
                        if (item.id_bit && item.cmp_bit)
                        begin
                            phase_next = PH_IDLE;
                            push.first.action = (alarm_flag_reg
                                && branch_index_reg >= NO_BRANCH) ? ACT_NONE : ACT_VANISHED;
                        end
                        else
                        begin
                            work_upd[bit_sel] = item.id_bit;
                            work_address_next = work_upd;
                            bit_index_next    = index_inc;
                            push.first.action = ACT_WRITE;
                            push.first.value  = {7'd0, item.id_bit};
                            if (index_inc >= NO_BRANCH)
                            begin
                                phase_next        = PH_IDLE;
                                push.count        = 2'd2;
                                push.first.last   = 1'b0;
                                push.second       = make_result(ACT_FOUND, 8'd0,
                                                                work_upd, 1'b1);
                            end
                        end
                    end
                    PH_DESCEND:
                    begin
                        push.count = 2'd1;
                        if (!pair_ok(item.id_bit, item.cmp_bit, addr_bit))
                        begin
                            phase_next        = PH_IDLE;
                            push.first.action = ACT_VANISHED;
                        end
                        else
                        begin
                            if (!item.id_bit && !item.cmp_bit && !addr_bit)
                                branch_index_next = bit_index_reg;
                            bit_index_next    = index_inc;
                            push.first.action = ACT_WRITE;
                            push.first.value  = {7'd0, addr_bit};
                            if (index_inc >= NO_BRANCH)
                            begin
                                push.count      = 2'd2;
                                push.first.last = 1'b0;
                                if (branch_index_next >= NO_BRANCH)
                                begin
                                    phase_next         = PH_IDLE;
                                    push.second.action = ACT_NONE;
                                end
                                else
                                begin
                                    phase_next         = PH_PRES_NEXT;
                                    push.second.action = ACT_RESET;
                                end
                            end
                        end
                    end
                    PH_TRACK:
                    begin
                        push.count = 2'd1;
                        if (bit_index_reg < branch_index_reg)
                        begin
                            if (!pair_ok(item.id_bit, item.cmp_bit, addr_bit))
                            begin
                                phase_next        = PH_IDLE;
                                push.first.action = ACT_VANISHED;
                            end
                            else
                            begin
                                bit_index_next    = index_inc;
                                push.first.action = ACT_WRITE;
                                push.first.value  = {7'd0, addr_bit};
                            end
                        end
                        else if (item.id_bit || item.cmp_bit)
                        begin
                            phase_next        = PH_IDLE;
                            push.first.action = ACT_VANISHED;
                        end
                        else
                        begin
                            work_upd[bit_sel] = 1'b1;
                            work_address_next = work_upd;
                            bit_index_next    = index_inc;
                            phase_next        = PH_TRAVERSE;
                            push.first.action = ACT_WRITE;
                            push.first.value  = 8'd1;
                            if (index_inc >= NO_BRANCH)
                            begin
                                phase_next      = PH_IDLE;
                                push.count      = 2'd2;
                                push.first.last = 1'b0;
                                push.second     = make_result(ACT_FOUND, 8'd0,
                                                              work_upd, 1'b1);
                            end
                        end
                    end
                    default:
                    begin
                        push.count = 2'd0;
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/owrs_result_fifo.sv =====
`default_nettype none

module owrs_result_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire owrs_pkg::push_t push,
    output logic                 room,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output owrs_pkg::result_t    result
);
    import owrs_pkg::*;

    result_t               mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]  head_reg, head_next;
    logic [RES_PTR_W-1:0]  tail_reg, tail_next;
    logic [RES_CNT_W-1:0]  count_reg, count_next;
    logic [1:0]            push_n;
    logic                  pop;

    assign push_n       = fire ? push.count : 2'd0;
    assign result_valid = (count_reg != '0);
    assign result       = mem_reg[head_reg];
    assign pop          = result_valid && !result_stall;
    assign room         = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));

    always_comb
    begin
        head_next  = pop ? head_reg + RES_PTR_W'(1) : head_reg;
        tail_next  = tail_reg + RES_PTR_W'(push_n);
        count_next = count_reg + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[tail_reg] <= push.first;
        if (push_n == 2'd2)
            mem_reg[tail_reg + RES_PTR_W'(1)] <= push.second;
    end

endmodule

`default_nettype wire

// ===== rtl/core/onewire_rom_search_engine_top.sv =====
`default_nettype none

// Master-side decision logic of the 1-Wire ROM search: each item (start, presence result
// or read bit pair) is taken into an input register and decided against the search state
// once the result queue has room; the decision pushes none, one or two results into that
// four-entry queue, which feeds the result port. One item can be taken every cycle while
// item_stall is low; an item that yields two results needs two result transfers, so the
// sustained rate is set by how fast the queue drains, and item_stall rises while an item
// waits in the input register and the queue holds more than two results.
module onewire_rom_search_engine_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire owrs_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output owrs_pkg::result_t      result
);
    import owrs_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    logic    room;
    logic    fire;
    logic    take;
    push_t   push;

    assign fire            = item_valid_reg && room;
    assign item_stall      = item_valid_reg && !room;
    assign take            = item_valid && !item_stall;
    assign item_valid_next = take || (item_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item;
    end

    owrs_decide u_decide (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .push  (push)
    );

    owrs_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/owrs_checker.sv =====
`default_nettype none

module owrs_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_stall,
    input  wire owrs_pkg::item_t   item,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire owrs_pkg::result_t result
);
    import owrs_pkg::*;

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("item changed while stalled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_found_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.action == ACT_FOUND |-> result.last)
        else $error("found result not marked last");

    a_addr_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.action != ACT_FOUND |-> result.address_out == 64'd0)
        else $error("address shown on a result other than found");

    a_byte_command: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.action == ACT_BYTE
            |-> result.value == CMD_SEARCH || result.value == CMD_ALARM)
        else $error("send byte with an unknown command");

endmodule

bind onewire_rom_search_engine_top owrs_checker u_checker (.*);

`default_nettype wire
